FILE: src/asx_pkg.sv
// ----------------------------------------------------------------------------
// asx_pkg : shared types and constants of the sponge XOF hash
// Holds the state type, the initial value, the round count and the
// round-constant helper used by the round unit and the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package asx_pkg;

    localparam int ASX_ROUNDS       = 12;
    localparam int ASX_RATE_BYTES   = 8;
    localparam int ASX_DIGEST_WORDS = 8;

    typedef logic [63:0]      t_word;
    typedef logic [4:0][63:0] t_state;
    typedef logic [3:0]       t_rnd;

    localparam t_word  ASX_IV       = 64'h0000_0800_00cc_0003;
    localparam t_state ASX_IV_STATE = {64'h0, 64'h0, 64'h0, 64'h0, ASX_IV};
    localparam t_rnd   ASX_LAST_RND = t_rnd'(ASX_ROUNDS - 1);

    // Round constant: high nibble counts down from 0xf, low nibble counts up.
    function automatic logic [7:0] asx_rc(input t_rnd rnd);
        logic [3:0] hi;
        hi = 4'hf - rnd;
        return {hi, rnd};
    endfunction

endpackage

`default_nettype wire

FILE: src/sponge_xof_hash.sv
// ----------------------------------------------------------------------------
// sponge_xof_hash : 64-bit rate sponge XOF hash, one round per cycle
// Absorbs one 8-byte block per item and squeezes DIGEST_WORDS digest words
// after the final, padded block, using a single shared round unit.
// ----------------------------------------------------------------------------
// Full block: accepted in ST_IDLE, then ASX_ROUNDS rounds run in ST_ABSORB;
//   the next item is taken only once the sequencer is back in ST_IDLE.
// Final block: after its rounds, ST_EMIT hands out the first digest word,
//   then each further word gets another round pass and emit, then ST_INIT
//   rebuilds the initial state before the next item (more while output stalls).
// Rounds use the one-round-per-cycle shared permutation unit. Reset: loads the
//   IV and runs an initial permutation pass; no item is accepted until it completes.
`default_nettype none

module sponge_xof_hash #(
    parameter int DIGEST_WORDS = asx_pkg::ASX_DIGEST_WORDS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [63:0] i_block_data,
    input  wire  [3:0]  i_valid_bytes,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [63:0] o_digest_word,
    output logic        o_last_word
);
    import asx_pkg::*;

    // word counter width; keep one bit for a single-word digest
    localparam int            WCW       = (DIGEST_WORDS > 1) ? $clog2(DIGEST_WORDS) : 1;
    localparam logic [WCW-1:0] LAST_WORD = WCW'(DIGEST_WORDS - 1);

    // sequencer codes
    localparam logic [1:0] ST_INIT   = 2'd0;  // permute freshly loaded IV
    localparam logic [1:0] ST_IDLE   = 2'd1;  // ready for the next item
    localparam logic [1:0] ST_ABSORB = 2'd2;  // 12 rounds on the state
    localparam logic [1:0] ST_EMIT   = 2'd3;  // hand the current digest word to the output

    logic [1:0]     r_state, n_state;
    t_rnd           r_cnt,   n_cnt;
    logic [WCW-1:0] r_wcnt,  n_wcnt;
    logic           r_final, n_final;
    t_state         r_sponge, n_sponge;
    t_state         round_out;

    logic           r_out_vld, n_out_vld;
    t_word          r_out_word;
    logic           r_out_last;

    logic           in_acc;
    logic           out_free;
    logic           out_load;
    logic           emit_last;
    t_word          absorb_word;

    asx_round u_round (
        .i_state (r_sponge),
        .i_rnd   (r_cnt),
        .o_state (round_out)
    );

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_vld || !i_out_stall;
    assign out_load   = (r_state == ST_EMIT) && out_free;
    assign emit_last  = (r_wcnt == LAST_WORD);

    // Build the absorbed word: keep valid bytes, put the pad byte just
    // after them; a count of eight or more keeps all bytes and drops the pad.
    always_comb begin
        for (int b = 0; b < ASX_RATE_BYTES; b++) begin
            if (4'(b) < i_valid_bytes) begin
                absorb_word[8*b +: 8] = i_block_data[8*b +: 8];
            end else if (4'(b) == i_valid_bytes) begin
                absorb_word[8*b +: 8] = 8'h01;
            end else begin
                absorb_word[8*b +: 8] = 8'h00;
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_wcnt   = r_wcnt;
        n_final  = r_final;
        n_sponge = r_sponge;
        case (r_state)
            ST_INIT: begin
                n_sponge = round_out;
                n_cnt    = r_cnt + 4'd1;
                if (r_cnt == ASX_LAST_RND) begin
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc) begin
                    n_sponge[0] = r_sponge[0] ^ absorb_word;
                    n_final     = !i_valid_bytes[3];
                    n_wcnt      = '0;
                    n_cnt       = '0;
                    n_state     = ST_ABSORB;
                end
            end
            ST_ABSORB: begin
                n_sponge = round_out;
                n_cnt    = r_cnt + 4'd1;
                if (r_cnt == ASX_LAST_RND) begin
                    n_cnt   = '0;
                    n_state = r_final ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT: begin
                // hold until the output register can take the word
                if (out_free) begin
                    if (emit_last) begin
                        n_sponge = ASX_IV_STATE;
                        n_final  = 1'b0;
                        n_cnt    = '0;
                        n_state  = ST_INIT;
                    end else begin
                        n_wcnt  = r_wcnt + WCW'(1);
                        n_cnt   = '0;
                        n_state = ST_ABSORB;
                    end
                end
            end
            default: begin
                n_state = ST_INIT;
                n_cnt   = '0;
            end
        endcase
    end

    assign n_out_vld = out_load || (r_out_vld && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_INIT;
            r_cnt     <= '0;
            r_wcnt    <= '0;
            r_final   <= 1'b0;
            r_out_vld <= 1'b0;
            r_sponge  <= ASX_IV_STATE;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_wcnt    <= n_wcnt;
            r_final   <= n_final;
            r_out_vld <= n_out_vld;
            r_sponge  <= n_sponge;
        end
    end

    // output payload: load on emit, otherwise hold
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_word <= r_sponge[0];
            r_out_last <= emit_last;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_digest_word = r_out_word;
    assign o_last_word   = r_out_last;

    // an accepted item always starts a fresh round count
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == ST_ABSORB) && (r_cnt == '0))
        else $error("accepted item did not start the permutation");

    // the squeeze is only reached on a final block
    a_emit_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> r_final)
        else $error("digest emit without a final block");

    // the permutation never ends early
    a_absorb_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ABSORB) && (r_cnt != ASX_LAST_RND) |=> (r_state == ST_ABSORB))
        else $error("permutation left before the last round");

    // the last digest word sends the sponge back to initialisation
    a_last_reinit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load && emit_last |=> (r_state == ST_INIT) && (r_cnt == '0) && r_out_last)
        else $error("last word did not restart the initial pass");

endmodule

`default_nettype wire

FILE: src/asx_round.sv
// ----------------------------------------------------------------------------
// asx_round : one round of the 320-bit sponge permutation
// Constant addition, 5-bit S-box layer and linear diffusion layer, all
// combinational; the sequencer applies it once per clock cycle while in ST_INIT or ST_ABSORB.
// ----------------------------------------------------------------------------
`default_nettype none

module asx_round (
    input  wire asx_pkg::t_state i_state,
    input  wire asx_pkg::t_rnd   i_rnd,
    output asx_pkg::t_state      o_state
);
    import asx_pkg::*;

    function automatic t_word rotr(input t_word v, input int r);
        return (v >> r) | (v << (64 - r));
    endfunction

    always_comb begin
        t_state x;
        t_state t;
        x = i_state;
        x[2] = x[2] ^ {56'h0, asx_rc(i_rnd)};
        // substitution layer
        x[0] = x[0] ^ x[4];
        x[4] = x[4] ^ x[3];
        x[2] = x[2] ^ x[1];
        t[0] = ~x[0] & x[1];
        t[1] = ~x[1] & x[2];
        t[2] = ~x[2] & x[3];
        t[3] = ~x[3] & x[4];
        t[4] = ~x[4] & x[0];
        x[0] = x[0] ^ t[1];
        x[1] = x[1] ^ t[2];
        x[2] = x[2] ^ t[3];
        x[3] = x[3] ^ t[4];
        x[4] = x[4] ^ t[0];
        x[1] = x[1] ^ x[0];
        x[0] = x[0] ^ x[4];
        x[3] = x[3] ^ x[2];
        x[2] = ~x[2];
        // linear layer
        o_state[0] = x[0] ^ rotr(x[0], 19) ^ rotr(x[0], 28);
        o_state[1] = x[1] ^ rotr(x[1], 61) ^ rotr(x[1], 39);
        o_state[2] = x[2] ^ rotr(x[2], 1)  ^ rotr(x[2], 6);
        o_state[3] = x[3] ^ rotr(x[3], 10) ^ rotr(x[3], 17);
        o_state[4] = x[4] ^ rotr(x[4], 7)  ^ rotr(x[4], 41);
    end

endmodule

`default_nettype wire
